FILE: rtl/assert_macros.svh
// Shared assertion helpers. Every check is clocked on clk_i and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, disabled while in reset.
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, but only at edges where the qualifier is high.
`define I2CM_ASSERT_IF(lbl, qual, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (qual) |-> (prop)) \
    else $error(msg);

`endif

FILE: rtl/i2cm_pkg.sv
package i2cm_pkg;

  localparam int unsigned DelayW = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CntW   = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] BitsPerByte = 4'd8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_STOP_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIT_DELAY        = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ACK_SETUP_DELAY  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACK_TIMEOUT      = 2'd3;

  localparam logic [DelayW-1:0] RST_START_STOP_DELAY = 8'd4;
  localparam logic [DelayW-1:0] RST_BIT_DELAY        = 8'd2;
  localparam logic [DelayW-1:0] RST_ACK_SETUP_DELAY  = 8'd1;
  localparam logic [DelayW-1:0] RST_ACK_TIMEOUT      = 8'd250;

  // Raw command codes on the kind field
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_WACK  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;
  localparam logic [2:0] KIND_ACK   = 3'd6;
  localparam logic [2:0] KIND_NACK  = 3'd7;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_WAIT_ACK,
    CMD_READ,
    CMD_ACK,
    CMD_NACK
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_A,
    PH_START_B,
    PH_STOP_A,
    PH_STOP_B,
    PH_W_SETUP,
    PH_W_HIGH,
    PH_W_LOW,
    PH_A_REL,
    PH_A_HIGH,
    PH_A_POLL,
    PH_R_LOW,
    PH_R_HIGH,
    PH_K_LOW,
    PH_K_HIGH
  } phase_e;

  // One classified tick
  typedef struct packed {
    cmd_e             cmd;
    logic [ByteW-1:0] tx_byte;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic               we;
    logic [CfgIdxW-1:0] idx;
    logic [DelayW-1:0]  data;
  } cfg_wr_t;

endpackage

FILE: rtl/i2cm_front.sv
module i2cm_front import i2cm_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       kind_i,
  input  logic [ByteW-1:0] tx_byte_i,
  input  logic             sda_in_i,
  output logic             item_valid_o,
  input  logic             item_ready_i,
  output item_t            item_o
);

  cmd_e cmd;

  always_comb begin
    unique case (kind_i)
      KIND_NONE:  cmd = CMD_NONE;
      KIND_START: cmd = CMD_START;
      KIND_STOP:  cmd = CMD_STOP;
      KIND_WRITE: cmd = CMD_WRITE;
      KIND_WACK:  cmd = CMD_WAIT_ACK;
      KIND_READ:  cmd = CMD_READ;
      KIND_ACK:   cmd = CMD_ACK;
      KIND_NACK:  cmd = CMD_NACK;
      default:    cmd = CMD_NONE;
    endcase
  end

  assign item_o.cmd     = cmd;
  assign item_o.tx_byte = tx_byte_i;
  assign item_o.sda_in  = sda_in_i;
  assign item_valid_o   = in_valid_i;
  assign in_ready_o     = item_ready_i;

endmodule

FILE: rtl/i2cm_queue.sv
module i2cm_queue import i2cm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  item_t             slot_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]    count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != QPtrW'(0) + (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/i2cm_back.sv
module i2cm_back import i2cm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_wr_t          cfg_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  item_t            item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             scl_level_o,
  output logic             sda_low_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [ByteW-1:0] rx_byte_o,
  output logic             ack_missing_o
);

  `include "assert_macros.svh"

  logic [DelayW-1:0] ss_delay_q, bit_delay_q, setup_delay_q, timeout_q;

  phase_e            phase_q, phase_d;
  logic [DelayW-1:0] dcnt_q, dcnt_d;
  logic [CntW-1:0]   bcnt_q, bcnt_d;
  logic [ByteW-1:0]  sout_q, sout_d;
  logic [ByteW-1:0]  sin_q, sin_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;
  logic              busy_q, done_q, done_d;
  logic              out_valid_q, out_valid_d;

  logic            take;
  logic            expired;
  logic [CntW-1:0] bcnt_inc;
  logic            last_bit;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign expired      = (dcnt_q <= DelayW'(1));
  assign bcnt_inc     = bcnt_q + CntW'(1);
  assign last_bit     = (bcnt_inc >= BitsPerByte);

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      if (phase_q == PH_IDLE) begin
        unique case (item_i.cmd)
          CMD_START:    phase_d = PH_START_A;
          CMD_STOP:     phase_d = PH_STOP_A;
          CMD_WRITE:    phase_d = PH_W_SETUP;
          CMD_WAIT_ACK: phase_d = PH_A_REL;
          CMD_READ:     phase_d = PH_R_LOW;
          CMD_ACK:      phase_d = PH_K_LOW;
          CMD_NACK:     phase_d = PH_K_LOW;
          default:      phase_d = PH_IDLE;
        endcase
      end else if (phase_q == PH_A_POLL) begin
        if (!item_i.sda_in || dcnt_q >= timeout_q) begin
          phase_d = PH_IDLE;
        end
      end else if (expired) begin
        unique case (phase_q)
          PH_START_A: phase_d = PH_START_B;
          PH_STOP_A:  phase_d = PH_STOP_B;
          PH_W_SETUP: phase_d = PH_W_HIGH;
          PH_W_HIGH:  phase_d = PH_W_LOW;
          PH_W_LOW:   phase_d = last_bit ? PH_IDLE : PH_W_SETUP;
          PH_A_REL:   phase_d = PH_A_HIGH;
          PH_A_HIGH:  phase_d = PH_A_POLL;
          PH_R_LOW:   phase_d = PH_R_HIGH;
          PH_R_HIGH:  phase_d = last_bit ? PH_IDLE : PH_R_LOW;
          PH_K_LOW:   phase_d = PH_K_HIGH;
          default:    phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Line drive, counters and shifters
  always_comb begin
    dcnt_d = dcnt_q;
    bcnt_d = bcnt_q;
    sout_d = sout_q;
    sin_d  = sin_q;
    scl_d  = scl_q;
    sda_d  = sda_q;
    ack_d  = ack_q;
    done_d = 1'b0;
    if (take) begin
      if (phase_q == PH_IDLE) begin
        unique case (item_i.cmd)
          CMD_START: begin
            scl_d  = 1'b1;
            sda_d  = 1'b0;
            dcnt_d = ss_delay_q;
          end
          CMD_STOP: begin
            scl_d  = 1'b0;
            sda_d  = 1'b1;
            dcnt_d = ss_delay_q;
          end
          CMD_WRITE: begin
            scl_d  = 1'b0;
            sout_d = item_i.tx_byte;
            bcnt_d = '0;
            sda_d  = !item_i.tx_byte[ByteW-1];
            dcnt_d = bit_delay_q;
          end
          CMD_WAIT_ACK: begin
            sda_d  = 1'b0;
            dcnt_d = setup_delay_q;
          end
          CMD_READ: begin
            scl_d  = 1'b0;
            sda_d  = 1'b0;
            sin_d  = '0;
            bcnt_d = '0;
            dcnt_d = bit_delay_q;
          end
          CMD_ACK: begin
            scl_d  = 1'b0;
            sda_d  = 1'b1;
            dcnt_d = bit_delay_q;
          end
          CMD_NACK: begin
            scl_d  = 1'b0;
            sda_d  = 1'b0;
            dcnt_d = bit_delay_q;
          end
          default: begin
          end
        endcase
      end else if (phase_q == PH_A_POLL) begin
        if (!item_i.sda_in) begin
          scl_d  = 1'b0;
          ack_d  = 1'b0;
          dcnt_d = '0;
          done_d = 1'b1;
        end else if (dcnt_q >= timeout_q) begin
          // timeout leaves SCL high
          ack_d  = 1'b1;
          dcnt_d = '0;
          done_d = 1'b1;
        end else begin
          dcnt_d = dcnt_q + DelayW'(1);
        end
      end else if (!expired) begin
        dcnt_d = dcnt_q - DelayW'(1);
      end else begin
        unique case (phase_q)
          PH_START_A: begin
            sda_d  = 1'b1;
            dcnt_d = ss_delay_q;
          end
          PH_START_B: begin
            scl_d  = 1'b0;
            dcnt_d = '0;
            done_d = 1'b1;
          end
          PH_STOP_A: begin
            scl_d  = 1'b1;
            sda_d  = 1'b0;
            dcnt_d = ss_delay_q;
          end
          PH_W_SETUP: begin
            scl_d  = 1'b1;
            dcnt_d = bit_delay_q;
          end
          PH_W_HIGH: begin
            scl_d  = 1'b0;
            dcnt_d = bit_delay_q;
          end
          PH_W_LOW: begin
            sout_d = {sout_q[ByteW-2:0], 1'b0};
            bcnt_d = bcnt_inc;
            if (last_bit) begin
              dcnt_d = '0;
              done_d = 1'b1;
            end else begin
              sda_d  = !sout_q[ByteW-2];
              dcnt_d = bit_delay_q;
            end
          end
          PH_A_REL: begin
            scl_d  = 1'b1;
            dcnt_d = setup_delay_q;
          end
          PH_A_HIGH: begin
            dcnt_d = '0;
          end
          PH_R_LOW: begin
            scl_d  = 1'b1;
            sin_d  = {sin_q[ByteW-2:0], item_i.sda_in};
            dcnt_d = bit_delay_q;
          end
          PH_R_HIGH: begin
            bcnt_d = bcnt_inc;
            if (last_bit) begin
              dcnt_d = '0;
              done_d = 1'b1;
            end else begin
              scl_d  = 1'b0;
              dcnt_d = bit_delay_q;
            end
          end
          PH_K_LOW: begin
            scl_d  = 1'b1;
            dcnt_d = bit_delay_q;
          end
          PH_K_HIGH: begin
            scl_d  = 1'b0;
            dcnt_d = '0;
            done_d = 1'b1;
          end
          default: begin
            dcnt_d = '0;
            done_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_delay_q    <= RST_START_STOP_DELAY;
      bit_delay_q   <= RST_BIT_DELAY;
      setup_delay_q <= RST_ACK_SETUP_DELAY;
      timeout_q     <= RST_ACK_TIMEOUT;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_START_STOP_DELAY: ss_delay_q    <= cfg_i.data;
        CFG_BIT_DELAY:        bit_delay_q   <= cfg_i.data;
        CFG_ACK_SETUP_DELAY:  setup_delay_q <= cfg_i.data;
        CFG_ACK_TIMEOUT:      timeout_q     <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      dcnt_q      <= '0;
      bcnt_q      <= '0;
      sout_q      <= '0;
      sin_q       <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b0;
      ack_q       <= 1'b0;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q <= phase_d;
        dcnt_q  <= dcnt_d;
        bcnt_q  <= bcnt_d;
        sout_q  <= sout_d;
        sin_q   <= sin_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        ack_q   <= ack_d;
        busy_q  <= (phase_d != PH_IDLE);
        done_q  <= done_d;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_level_o   = scl_q;
  assign sda_low_o     = sda_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;
  assign rx_byte_o     = sin_q;
  assign ack_missing_o = ack_q;

  `I2CM_ASSERT(a_busy_tracks_phase, busy_q == (phase_q != PH_IDLE), "busy flag out of step with phase")
  `I2CM_ASSERT_IF(a_done_not_busy, done_q, !busy_q, "done reported while still busy")
  `I2CM_ASSERT_IF(a_poll_scl_high, phase_q == PH_A_POLL, scl_q, "SCL low during ack polling")
  `I2CM_ASSERT(a_bit_count_range, bcnt_q <= BitsPerByte, "bit counter past one byte")

endmodule

FILE: rtl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: one bus tick per request, one result per tick.
// Path: a request is held in the queue, then its result is registered at the output.
// Throughput: one request per cycle while neither side stalls; the two-entry queue and
// the output register absorb stalls, but a full queue takes no request until one leaves.
// Reset (async, active low): phase idle, SCL released high, SDA released, flags and
// shift registers cleared, delay registers back to 4/2/1/250.
module i2c_master_bit_sequencer import i2cm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DelayW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic [ByteW-1:0]   tx_byte_i,
  input  logic               sda_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               scl_level_o,
  output logic               sda_low_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [ByteW-1:0]   rx_byte_o,
  output logic               ack_missing_o
);

  item_t   fr_item, q_item;
  logic    fr_valid, fr_ready;
  logic    q_valid, q_ready;
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  i2cm_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .tx_byte_i    (tx_byte_i),
    .sda_in_i     (sda_in_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  i2cm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_valid_i  (q_valid),
    .item_ready_o  (q_ready),
    .item_i        (q_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_level_o   (scl_level_o),
    .sda_low_o     (sda_low_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_missing_o (ack_missing_o)
  );

endmodule

FILE: bench/i2c_master_bit_sequencer_test.sv
module i2c_master_bit_sequencer_test;
  import i2cm_pkg::*;

  localparam int NoAck      = 1000;  // sda never goes low during polling
  localparam int StuckLimit = 1000;

  typedef struct {
    logic [2:0]       kind;
    logic [ByteW-1:0] tx;
    logic             sda;
  } bus_tick_t;

  typedef struct {
    logic             scl;
    logic             sda_low;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx;
    logic             ack_missing;
  } line_state_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DelayW-1:0]  cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         kind_i = '0;
  logic [ByteW-1:0]   tx_byte_i = '0;
  logic               sda_in_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               scl_level_o;
  logic               sda_low_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic [ByteW-1:0]   rx_byte_o;
  logic               ack_missing_o;

  i2c_master_bit_sequencer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .tx_byte_i,
    .sda_in_i,
    .out_valid_o,
    .out_ready_i,
    .scl_level_o,
    .sda_low_o,
    .busy_res_o,
    .done_res_o,
    .rx_byte_o,
    .ack_missing_o
  );

  always #5 clk_i = ~clk_i;

  bus_tick_t   pending_ticks[$];
  line_state_t expected_lines[$];

  int errors = 0;
  int n_ticks = 0;
  int n_cmds = 0;
  int n_timeouts = 0;
  int n_settings = 0;
  logic hold_req = 1'b0;

  // Sequencer state mirrored here
  logic [DelayW-1:0] cfg_ss = RST_START_STOP_DELAY;
  logic [DelayW-1:0] cfg_bit = RST_BIT_DELAY;
  logic [DelayW-1:0] cfg_setup = RST_ACK_SETUP_DELAY;
  logic [DelayW-1:0] cfg_timeout = RST_ACK_TIMEOUT;
  phase_e            seq_phase = PH_IDLE;
  logic [DelayW-1:0] seq_cnt = '0;
  logic [CntW-1:0]   seq_bits = '0;
  logic [ByteW-1:0]  seq_tx = '0;
  logic [ByteW-1:0]  seq_rx = '0;
  logic              seq_scl = 1'b1;
  logic              seq_sda_pull = 1'b0;
  logic              seq_nack = 1'b0;

  // Advance the line sequencer by one tick, return the line state after it.
  function automatic line_state_t bus_tick(input logic [2:0] kind,
                                           input logic [ByteW-1:0] tx, input logic sda);
    line_state_t r;
    logic fin;
    fin = 1'b0;
    if (seq_phase == PH_IDLE) begin
      case (kind)
        KIND_START: begin
          seq_scl = 1'b1; seq_sda_pull = 1'b0; seq_phase = PH_START_A; seq_cnt = cfg_ss;
        end
        KIND_STOP: begin
          seq_scl = 1'b0; seq_sda_pull = 1'b1; seq_phase = PH_STOP_A; seq_cnt = cfg_ss;
        end
        KIND_WRITE: begin
          seq_scl = 1'b0; seq_tx = tx; seq_bits = '0; seq_sda_pull = ~tx[7];
          seq_phase = PH_W_SETUP; seq_cnt = cfg_bit;
        end
        KIND_WACK: begin
          seq_sda_pull = 1'b0; seq_phase = PH_A_REL; seq_cnt = cfg_setup;
        end
        KIND_READ: begin
          seq_sda_pull = 1'b0; seq_scl = 1'b0; seq_rx = '0; seq_bits = '0;
          seq_phase = PH_R_LOW; seq_cnt = cfg_bit;
        end
        KIND_ACK: begin
          seq_scl = 1'b0; seq_sda_pull = 1'b1; seq_phase = PH_K_LOW; seq_cnt = cfg_bit;
        end
        KIND_NACK: begin
          seq_scl = 1'b0; seq_sda_pull = 1'b0; seq_phase = PH_K_LOW; seq_cnt = cfg_bit;
        end
        default: ;
      endcase
    end else if (seq_phase == PH_A_POLL) begin
      if (!sda) begin
        seq_scl = 1'b0; seq_nack = 1'b0; fin = 1'b1;
      end else if (seq_cnt >= cfg_timeout) begin
        seq_nack = 1'b1; fin = 1'b1;
      end else begin
        seq_cnt = seq_cnt + 1'b1;
      end
    end else if (seq_cnt > 1) begin
      seq_cnt = seq_cnt - 1'b1;
    end else begin
      // phase expired: move on, or finish unless the branch says otherwise
      fin = 1'b1;
      case (seq_phase)
        PH_START_A: begin
          seq_sda_pull = 1'b1; seq_phase = PH_START_B; seq_cnt = cfg_ss; fin = 1'b0;
        end
        PH_START_B: seq_scl = 1'b0;
        PH_STOP_A: begin
          seq_scl = 1'b1; seq_sda_pull = 1'b0; seq_phase = PH_STOP_B; seq_cnt = cfg_ss;
          fin = 1'b0;
        end
        PH_STOP_B: ;
        PH_W_SETUP: begin
          seq_scl = 1'b1; seq_phase = PH_W_HIGH; seq_cnt = cfg_bit; fin = 1'b0;
        end
        PH_W_HIGH: begin
          seq_scl = 1'b0; seq_phase = PH_W_LOW; seq_cnt = cfg_bit; fin = 1'b0;
        end
        PH_W_LOW: begin
          seq_tx = seq_tx << 1;
          seq_bits = seq_bits + 1'b1;
          if (seq_bits < BitsPerByte) begin
            seq_sda_pull = ~seq_tx[7]; seq_phase = PH_W_SETUP; seq_cnt = cfg_bit; fin = 1'b0;
          end
        end
        PH_A_REL: begin
          seq_scl = 1'b1; seq_phase = PH_A_HIGH; seq_cnt = cfg_setup; fin = 1'b0;
        end
        PH_A_HIGH: begin
          seq_phase = PH_A_POLL; seq_cnt = '0; fin = 1'b0;
        end
        PH_R_LOW: begin
          seq_scl = 1'b1; seq_rx = {seq_rx[ByteW-2:0], sda};
          seq_phase = PH_R_HIGH; seq_cnt = cfg_bit; fin = 1'b0;
        end
        PH_R_HIGH: begin
          seq_bits = seq_bits + 1'b1;
          if (seq_bits < BitsPerByte) begin
            seq_scl = 1'b0; seq_phase = PH_R_LOW; seq_cnt = cfg_bit; fin = 1'b0;
          end
        end
        PH_K_LOW: begin
          seq_scl = 1'b1; seq_phase = PH_K_HIGH; seq_cnt = cfg_bit; fin = 1'b0;
        end
        PH_K_HIGH: seq_scl = 1'b0;
        default: ;
      endcase
    end
    if (fin) begin
      seq_phase = PH_IDLE;
      seq_cnt = '0;
    end
    r.scl = seq_scl;
    r.sda_low = seq_sda_pull;
    r.busy = (seq_phase != PH_IDLE);
    r.done = fin;
    r.rx = seq_rx;
    r.ack_missing = seq_nack;
    return r;
  endfunction

  task automatic push_tick(input logic [2:0] kind, input logic [ByteW-1:0] tx,
                           input logic sda);
    bus_tick_t t;
    t.kind = kind;
    t.tx = tx;
    t.sda = sda;
    expected_lines.push_back(bus_tick(kind, tx, sda));
    pending_ticks.push_back(t);
    n_ticks++;
  endtask

  function automatic int pick_ack();
    return ($urandom_range(0, 4) == 0) ? NoAck : $urandom_range(0, 5);
  endfunction

  // Issue one command on an idle sequencer and tick it through to completion.
  // ack_after: high samples before the slave pulls sda low during polling.
  task automatic run_cmd(input logic [2:0] kind, input logic [ByteW-1:0] tx,
                         input int ack_after);
    int polled;
    polled = 0;
    push_tick(kind, tx, 1'($urandom_range(0, 1)));
    while (seq_phase != PH_IDLE) begin
      if (seq_phase == PH_A_POLL) begin
        push_tick(3'($urandom_range(0, 7)), 8'($urandom), (polled >= ack_after) ? 1'b0 : 1'b1);
        polled++;
      end else begin
        // kind is ignored while busy, so any value goes
        push_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    if (kind != KIND_NONE) n_cmds++;
    if (kind == KIND_WACK && seq_nack) n_timeouts++;
    if ($urandom_range(0, 1) == 0)
      repeat ($urandom_range(1, 3)) push_tick(KIND_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic bus_transaction();
    int n;
    bit rd;
    n = $urandom_range(0, 3);
    rd = $urandom_range(0, 1);
    if ($urandom_range(0, 5) == 0) begin
      run_cmd(3'($urandom_range(0, 7)), 8'($urandom), pick_ack());
      return;
    end
    run_cmd(KIND_START, '0, 0);
    run_cmd(KIND_WRITE, 8'($urandom), 0);
    run_cmd(KIND_WACK, '0, pick_ack());
    for (int i = 0; i < n; i++) begin
      if (rd) begin
        run_cmd(KIND_READ, '0, 0);
        run_cmd((i == n - 1) ? KIND_NACK : KIND_ACK, '0, 0);
      end else begin
        run_cmd(KIND_WRITE, 8'($urandom), 0);
        run_cmd(KIND_WACK, '0, pick_ack());
      end
    end
    run_cmd(KIND_STOP, '0, 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_START_STOP_DELAY: cfg_ss = v;
      CFG_BIT_DELAY:        cfg_bit = v;
      CFG_ACK_SETUP_DELAY:  cfg_setup = v;
      CFG_ACK_TIMEOUT:      cfg_timeout = v;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_delays(input logic [DelayW-1:0] ss, input logic [DelayW-1:0] bd,
                              input logic [DelayW-1:0] sd, input logic [DelayW-1:0] to);
    write_reg(CFG_START_STOP_DELAY, ss);
    write_reg(CFG_BIT_DELAY, bd);
    write_reg(CFG_ACK_SETUP_DELAY, sd);
    write_reg(CFG_ACK_TIMEOUT, to);
    n_settings++;
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || expected_lines.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: bursts of requests with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_valid_i <= 1'b1;
        kind_i <= pending_ticks[0].kind;
        tx_byte_i <= pending_ticks[0].tx;
        sda_in_i <= pending_ticks[0].sda;
        pending_ticks.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall mode changes every so often, plus long hold-offs on request
  int   hold_left = 0;
  logic hold_seen = 1'b0;
  int   stall_mode = 0;
  int   mode_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 120;
        out_ready_i <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ($urandom_range(0, 2) == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    line_state_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_lines.size() == 0) begin
        $error("unexpected result: scl=%0b sda_low=%0b busy=%0b done=%0b",
               scl_level_o, sda_low_o, busy_res_o, done_res_o);
        errors++;
      end else begin
        e = expected_lines.pop_front();
        if (scl_level_o !== e.scl) begin
          $error("scl_level: expected %0b, got %0b", e.scl, scl_level_o);
          errors++;
        end
        if (sda_low_o !== e.sda_low) begin
          $error("sda_low: expected %0b, got %0b", e.sda_low, sda_low_o);
          errors++;
        end
        if (busy_res_o !== e.busy) begin
          $error("busy_res: expected %0b, got %0b", e.busy, busy_res_o);
          errors++;
        end
        if (done_res_o !== e.done) begin
          $error("done_res: expected %0b, got %0b", e.done, done_res_o);
          errors++;
        end
        if (rx_byte_o !== e.rx) begin
          $error("rx_byte: expected %02h, got %02h", e.rx, rx_byte_o);
          errors++;
        end
        if (ack_missing_o !== e.ack_missing) begin
          $error("ack_missing: expected %0b, got %0b", e.ack_missing, ack_missing_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: no handshake on either side for too long while results are owed
  int stuck = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        expected_lines.size() == 0) begin
      stuck <= 0;
    end else if (stuck >= StuckLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset delays: every command, byte extremes, early ack, late ack, timeout
    run_cmd(KIND_NONE, 8'hFF, 0);
    run_cmd(KIND_START, 8'h00, 0);
    run_cmd(KIND_WRITE, 8'hFF, 0);
    run_cmd(KIND_WACK, '0, 0);
    run_cmd(KIND_WRITE, 8'h00, 0);
    run_cmd(KIND_WACK, '0, 3);
    run_cmd(KIND_WRITE, 8'hA5, 0);
    run_cmd(KIND_WACK, '0, NoAck);
    run_cmd(KIND_READ, '0, 0);
    run_cmd(KIND_ACK, '0, 0);
    run_cmd(KIND_READ, '0, 0);
    run_cmd(KIND_NACK, '0, 0);
    run_cmd(KIND_STOP, '0, 0);
    drain();

    // Zero delays act as one tick; zero timeout fails on the first high sample
    apply_delays(8'd0, 8'd0, 8'd0, 8'd0);
    run_cmd(KIND_START, '0, 0);
    run_cmd(KIND_WRITE, 8'h3C, 0);
    run_cmd(KIND_WACK, '0, 0);
    run_cmd(KIND_WACK, '0, NoAck);
    run_cmd(KIND_READ, '0, 0);
    run_cmd(KIND_ACK, '0, 0);
    run_cmd(KIND_NACK, '0, 0);
    run_cmd(KIND_STOP, '0, 0);
    repeat (2) bus_transaction();
    drain();

    apply_delays(8'd1, 8'd1, 8'd1, 8'd1);
    repeat (4) bus_transaction();
    hold_req <= ~hold_req;
    drain();

    for (int s = 0; s < 3; s++) begin
      int base;
      base = n_ticks;
      apply_delays(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                   8'($urandom_range(1, 5)), 8'($urandom_range(0, 12)));
      while (n_ticks - base < 150) bus_transaction();
      if (s == 1) hold_req <= ~hold_req;
      drain();
    end

    // Longest acknowledge timeout, kept to a handful of commands
    apply_delays(8'd3, 8'd1, 8'd2, 8'd255);
    run_cmd(KIND_START, '0, 0);
    run_cmd(KIND_WACK, '0, 7);
    run_cmd(KIND_WACK, '0, NoAck);
    run_cmd(KIND_NACK, '0, 0);
    drain();

    repeat (10) @(posedge clk_i);
    if (expected_lines.size() != 0) begin
      $error("%0d results never arrived", expected_lines.size());
      errors++;
    end
    $display("Covered %0d ticks and %0d commands over %0d delay settings,",
             n_ticks, n_cmds, n_settings);
    $display("including %0d acknowledge timeouts; %0d mismatches.", n_timeouts, errors);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
